### rtl/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// Shared constants, codes and controller/datapath interface types for the
// contiguous bitmap allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

    localparam int MAP_BLOCKS_DEF = 32768;
    localparam int WORD_BITS_DEF  = 32;

    // fixed field widths
    localparam int REG_W  = 16;
    localparam int WANT_W = 16;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int RES_W  = 15;
    localparam int APB_W  = 32;
    localparam int ADDR_W = 3;
    // block positions never exceed the 16-bit volume size plus one word
    localparam int POS_W  = 17;

    localparam logic [REG_W-1:0] TOTAL_RESET = 16'd0;
    localparam logic [REG_W-1:0] FDB_RESET   = 16'd6;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_LOAD  = 1'b1;

    // register select, taken from paddr[2]
    localparam logic REG_TOTAL = 1'b0;
    localparam logic REG_FDB   = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic acc_load;
        logic acc_nil;
        logic scan_init;
        logic scan_prime;
        logic scan_step;
        logic mark_rd;
        logic mark_wr;
    } cba_cmd_t;

    typedef struct packed {
        logic wanted_zero;
        logic clr_last;
        logic scan_hit;
        logic scan_last;
        logic mark_last;
    } cba_stat_t;

endpackage

### rtl/cba_ctrl.sv
// ----------------------------------------------------------------------------
// cba_ctrl
// Sequencer: clearing pass, request decode, word scan and run marking.
// ----------------------------------------------------------------------------
module cba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               func,
    input  cba_pkg::cba_stat_t stat,
    output logic               busy,
    output logic               done,
    output cba_pkg::cba_cmd_t  cmd
);
    import cba_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PRIME = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_MRD   = 3'd4;
    localparam logic [2:0] ST_MWR   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        cmd.acc_load = 1'b1;
                        done_next    = 1'b1;
                    end
                    else if (stat.wanted_zero)
                    begin
                        cmd.acc_nil = 1'b1;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_PRIME;
                    end
                end
            end
            ST_PRIME:
            begin
                cmd.scan_prime = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit)
                    state_next = ST_MRD;
                else if (stat.scan_last)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_MRD:
            begin
                cmd.mark_rd = 1'b1;
                state_next  = ST_MWR;
            end
            ST_MWR:
            begin
                cmd.mark_wr = 1'b1;
                if (stat.mark_last)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                    state_next = ST_MRD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

### rtl/cba_datapath.sv
// ----------------------------------------------------------------------------
// cba_datapath
// Bitmap memory, word-wide free-run search and read-modify-write marking.
// ----------------------------------------------------------------------------
module cba_datapath #(
    parameter int MAP_BLOCKS = cba_pkg::MAP_BLOCKS_DEF,
    parameter int WORD_BITS  = cba_pkg::WORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cba_pkg::cba_cmd_t           cmd,
    input  logic [cba_pkg::REG_W-1:0]   total_block_count,
    input  logic [cba_pkg::REG_W-1:0]   first_data_block,
    input  logic [cba_pkg::WANT_W-1:0]  blocks_wanted,
    input  logic [cba_pkg::IDX_W-1:0]   word_index,
    input  logic [cba_pkg::VAL_W-1:0]   word_value,
    output cba_pkg::cba_stat_t          stat,
    output logic                        granted,
    output logic [cba_pkg::RES_W-1:0]   run_first_block
);
    import cba_pkg::*;

    localparam int MAP_WORDS = MAP_BLOCKS / WORD_BITS;
    localparam int MAP_BITS  = MAP_WORDS * WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OW        = $clog2(WORD_BITS);
    localparam int CW        = $clog2(WORD_BITS + 1);
    localparam int LIM_CAP   = (MAP_BITS > 65535) ? 65535 : MAP_BITS;

    localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [REG_W-1:0] LIMIT_MAX = REG_W'(LIM_CAP);
    localparam logic [CW-1:0]    W_CNT     = CW'(WORD_BITS);
    localparam logic [POS_W-1:0] W_POS     = POS_W'(WORD_BITS);

    logic [WORD_BITS-1:0] used_map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;

    logic [AW-1:0]     cur_word_reg;
    logic [POS_W-1:0]  base_reg;
    logic [POS_W-1:0]  run_len_reg;
    logic [POS_W-1:0]  run_blk_reg;
    logic [AW-1:0]     run_word_reg;
    logic [OW-1:0]     run_off_reg;
    logic [WANT_W-1:0] wanted_reg;
    logic [AW-1:0]     mark_addr_reg;
    logic [OW-1:0]     mark_off_reg;
    logic [WANT_W-1:0] mark_rem_reg;
    logic              granted_reg;
    logic [RES_W-1:0]  res_blk_reg;

    logic [REG_W-1:0]     limit;
    logic [POS_W-1:0]     fdb_pos;
    logic [POS_W-1:0]     lim_pos;
    logic [POS_W-1:0]     lo_raw;
    logic [POS_W-1:0]     hi_raw;
    logic [CW-1:0]        lo;
    logic [CW-1:0]        hi;
    logic [WORD_BITS-1:0] free_vec;
    logic [WORD_BITS-1:0] ok_vec;
    logic [CW-1:0]        lead_free;
    logic [CW-1:0]        trail_free;
    logic [OW-1:0]        first_ok;
    logic                 all_free;
    logic                 wanted_fits;
    logic                 hit_a;
    logic                 hit_b;
    logic                 scan_last;
    logic                 in_range;

    logic [CW-1:0]        rem_c;
    logic [CW:0]          end_raw;
    logic [CW-1:0]        end_c;
    logic [CW-1:0]        taken;
    logic [WORD_BITS-1:0] mark_mask;

    logic                 wen;
    logic [AW-1:0]        waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [AW-1:0]        raddr;

    assign limit   = (total_block_count > LIMIT_MAX) ? LIMIT_MAX : total_block_count;
    assign fdb_pos = POS_W'(first_data_block);
    assign lim_pos = POS_W'(limit);

    // window of allowed bit positions in the word under scan
    assign lo_raw = (fdb_pos > base_reg) ? fdb_pos - base_reg : '0;
    assign hi_raw = (lim_pos > base_reg) ? lim_pos - base_reg : '0;
    assign lo     = (lo_raw > W_POS) ? W_CNT : lo_raw[CW-1:0];
    assign hi     = (hi_raw > W_POS) ? W_CNT : hi_raw[CW-1:0];

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
            free_vec[j] = !rdata_reg[j] && (CW'(j) >= lo) && (CW'(j) < hi);
    end

    // ok_vec[s]: blocks s .. s+wanted-1 of this word are all free (when wanted fits the word)
    always_comb
    begin
        ok_vec = '1;
        for (int k = 0; k < WORD_BITS; k++)
        begin
            if (32'(k) < 32'(wanted_reg))
                ok_vec = ok_vec & (free_vec >> k);
        end
    end

    always_comb
    begin
        trail_free = W_CNT;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (!free_vec[j])
                trail_free = CW'(j);
        end
    end

    always_comb
    begin
        lead_free = W_CNT;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (!free_vec[j])
                lead_free = CW'(WORD_BITS - 1 - j);
        end
    end

    always_comb
    begin
        first_ok = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (ok_vec[j])
                first_ok = OW'(j);
        end
    end

    assign all_free    = &free_vec;
    assign wanted_fits = (32'(wanted_reg) <= 32'(WORD_BITS));
    // a run carried in from lower words finishes inside the free prefix
    assign hit_a       = (run_len_reg + POS_W'(trail_free)) >= POS_W'(wanted_reg);
    assign hit_b       = wanted_fits && (|ok_vec);
    assign scan_last   = ((base_reg + W_POS) >= lim_pos) || (cur_word_reg == LAST_WORD);
    assign in_range    = (32'(word_index) < 32'(MAP_WORDS));

    // marking: bits mark_off .. end_c-1 of the current word
    assign rem_c   = (32'(mark_rem_reg) > 32'(WORD_BITS)) ? W_CNT : CW'(mark_rem_reg);
    assign end_raw = (CW+1)'(mark_off_reg) + (CW+1)'(rem_c);
    assign end_c   = (end_raw > (CW+1)'(WORD_BITS)) ? W_CNT : end_raw[CW-1:0];
    assign taken   = end_c - CW'(mark_off_reg);

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
            mark_mask[j] = (CW'(j) >= CW'(mark_off_reg)) && (CW'(j) < end_c);
    end

    // memory port selection
    always_comb
    begin
        wen   = 1'b0;
        waddr = cur_word_reg;
        wdata = '0;
        if (cmd.clr_step)
            wen = 1'b1;
        else if (cmd.acc_load)
        begin
            wen   = in_range;
            waddr = AW'(word_index);
            wdata = WORD_BITS'(word_value);
        end
        else if (cmd.mark_wr)
        begin
            wen   = 1'b1;
            waddr = mark_addr_reg;
            wdata = rdata_reg | mark_mask;
        end
    end

    always_comb
    begin
        if (cmd.mark_rd)
            raddr = mark_addr_reg;
        else if (cmd.scan_prime)
            raddr = '0;
        else
            raddr = cur_word_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wen)
            used_map_mem[waddr] <= wdata;
        rdata_reg <= used_map_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_word_reg  <= '0;
            base_reg      <= '0;
            run_len_reg   <= '0;
            run_blk_reg   <= '0;
            run_word_reg  <= '0;
            run_off_reg   <= '0;
            wanted_reg    <= '0;
            mark_addr_reg <= '0;
            mark_off_reg  <= '0;
            mark_rem_reg  <= '0;
            granted_reg   <= 1'b0;
            res_blk_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_step)
                cur_word_reg <= cur_word_reg + 1'b1;

            if (cmd.acc_load)
            begin
                granted_reg <= in_range;
                res_blk_reg <= '0;
            end

            if (cmd.acc_nil)
            begin
                granted_reg <= 1'b0;
                res_blk_reg <= '0;
            end

            if (cmd.scan_init)
            begin
                wanted_reg   <= blocks_wanted;
                cur_word_reg <= '0;
                base_reg     <= '0;
                run_len_reg  <= '0;
            end

            if (cmd.scan_step)
            begin
                cur_word_reg <= cur_word_reg + 1'b1;
                base_reg     <= base_reg + W_POS;
                if (hit_a || hit_b)
                begin
                    granted_reg  <= 1'b1;
                    mark_rem_reg <= wanted_reg;
                    if (hit_a && (run_len_reg != '0))
                    begin
                        res_blk_reg   <= run_blk_reg[RES_W-1:0];
                        mark_addr_reg <= run_word_reg;
                        mark_off_reg  <= run_off_reg;
                    end
                    else if (hit_a)
                    begin
                        res_blk_reg   <= base_reg[RES_W-1:0];
                        mark_addr_reg <= cur_word_reg;
                        mark_off_reg  <= '0;
                    end
                    else
                    begin
                        res_blk_reg   <= RES_W'(base_reg + POS_W'(first_ok));
                        mark_addr_reg <= cur_word_reg;
                        mark_off_reg  <= first_ok;
                    end
                end
                else
                begin
                    if (scan_last)
                    begin
                        granted_reg <= 1'b0;
                        res_blk_reg <= '0;
                    end
                    if (all_free)
                    begin
                        if (run_len_reg == '0)
                        begin
                            run_blk_reg  <= base_reg;
                            run_word_reg <= cur_word_reg;
                            run_off_reg  <= '0;
                        end
                        run_len_reg <= run_len_reg + W_POS;
                    end
                    else
                    begin
                        // free tail of this word opens a new run
                        run_len_reg  <= POS_W'(lead_free);
                        run_blk_reg  <= base_reg + W_POS - POS_W'(lead_free);
                        run_word_reg <= cur_word_reg;
                        run_off_reg  <= OW'(W_CNT - lead_free);
                    end
                end
            end

            if (cmd.mark_wr)
            begin
                mark_addr_reg <= mark_addr_reg + 1'b1;
                mark_off_reg  <= '0;
                mark_rem_reg  <= mark_rem_reg - WANT_W'(taken);
            end
        end
    end

    assign stat.wanted_zero = (blocks_wanted == '0);
    assign stat.clr_last    = (cur_word_reg == LAST_WORD);
    assign stat.scan_hit    = hit_a || hit_b;
    assign stat.scan_last   = scan_last;
    assign stat.mark_last   = (WANT_W'(taken) == mark_rem_reg);

    assign granted         = granted_reg;
    assign run_first_block = res_blk_reg;

endmodule

### rtl/contiguous_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// contiguous_bitmap_allocator_core
// First-fit allocator of contiguous free runs over a used-block bitmap.
// ----------------------------------------------------------------------------
//  Channel   Handshake                   Payload
//  request   start / busy                func, blocks_wanted, word_index, word_value
//  result    done (one-cycle strobe)     granted, run_first_block
//  config    APB (psel/penable/pready)   paddr, pwdata, prdata
//
//  Load and zero-count requests: result strobe one cycle after the transfer.
//  Allocate: a priming read, then N words scanned at one memory read per
//  cycle (up to MAP_BLOCKS/WORD_BITS, 1024 by default), M words marked by
//  read-modify-write on the single write port, then the result strobe.
//  After reset a clearing pass writes MAP_BLOCKS/WORD_BITS words (1024 by
//  default) with busy high; register writes are taken during it.
//  The receiver cannot stall: each result is valid for the done cycle only.
// ----------------------------------------------------------------------------
module contiguous_bitmap_allocator_core #(
    parameter int MAP_BLOCKS = cba_pkg::MAP_BLOCKS_DEF,
    parameter int WORD_BITS  = cba_pkg::WORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        func,
    input  logic [cba_pkg::WANT_W-1:0]  blocks_wanted,
    input  logic [cba_pkg::IDX_W-1:0]   word_index,
    input  logic [cba_pkg::VAL_W-1:0]   word_value,
    output logic                        done,
    output logic                        granted,
    output logic [cba_pkg::RES_W-1:0]   run_first_block,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cba_pkg::ADDR_W-1:0]  paddr,
    input  logic [cba_pkg::APB_W-1:0]   pwdata,
    output logic [cba_pkg::APB_W-1:0]   prdata,
    output logic                        pready
);
    import cba_pkg::*;

    logic [REG_W-1:0] total_reg;
    logic [REG_W-1:0] fdb_reg;
    logic             cfg_wr;
    cba_cmd_t         cmd;
    cba_stat_t        stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
            fdb_reg   <= FDB_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_TOTAL: total_reg <= pwdata[REG_W-1:0];
                REG_FDB:   fdb_reg   <= pwdata[REG_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TOTAL: prdata = APB_W'(total_reg);
            REG_FDB:   prdata = APB_W'(fdb_reg);
            default:   prdata = '0;
        endcase
    end

    cba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    cba_datapath #(
        .MAP_BLOCKS (MAP_BLOCKS),
        .WORD_BITS  (WORD_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .total_block_count (total_reg),
        .first_data_block  (fdb_reg),
        .blocks_wanted     (blocks_wanted),
        .word_index        (word_index),
        .word_value        (word_value),
        .stat              (stat),
        .granted           (granted),
        .run_first_block   (run_first_block)
    );

    // a result is only ever shown with the sequencer back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !granted) |-> (run_first_block == '0))
        else $error("failed result carries a block number");

    a_nil_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == FUNC_ALLOC) && (blocks_wanted == '0))
            |=> (done && !granted))
        else $error("zero-count allocate not refused at once");

    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == FUNC_LOAD)) |=> done)
        else $error("load transfer gave no result next cycle");

endmodule

### tb/sv/cba_alloc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cba_alloc_checker
// Snoops the request, result and register channels of the allocator, keeps a
// private copy of the used-block bitmap and volume registers, predicts the
// outcome of every accepted request and checks the result strobes in order.
// ----------------------------------------------------------------------------
module cba_alloc_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        func,
    input  logic [cba_pkg::WANT_W-1:0]  blocks_wanted,
    input  logic [cba_pkg::IDX_W-1:0]   word_index,
    input  logic [cba_pkg::VAL_W-1:0]   word_value,
    input  logic                        done,
    input  logic                        granted,
    input  logic [cba_pkg::RES_W-1:0]   run_first_block,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [cba_pkg::ADDR_W-1:0]  paddr,
    input  logic [cba_pkg::APB_W-1:0]   pwdata,
    output int                          mismatch_count,
    output int                          awaited_count,
    output int                          runs_granted,
    output int                          runs_refused,
    output int                          words_loaded
);

    localparam int WORD_BITS = cba_pkg::WORD_BITS_DEF;
    localparam int MAP_WORDS = cba_pkg::MAP_BLOCKS_DEF / WORD_BITS;
    localparam int MAP_BITS  = MAP_WORDS * WORD_BITS;

    typedef struct packed {
        logic                       granted;
        logic [cba_pkg::RES_W-1:0]  run_first_block;
    } outcome_t;

    logic [WORD_BITS-1:0]       used_map [MAP_WORDS];
    logic [cba_pkg::REG_W-1:0]  volume_blocks;
    logic [cba_pkg::REG_W-1:0]  data_start;
    outcome_t                   awaited_outcomes [$];
    outcome_t                   head;
    outcome_t                   seen;

    // first-fit search over the private bitmap, marking the run on success; a load writes one word
    function automatic outcome_t first_fit_outcome(
        input logic                         op,
        input logic [cba_pkg::WANT_W-1:0]   want,
        input logic [cba_pkg::IDX_W-1:0]    idx,
        input logic [cba_pkg::VAL_W-1:0]    val
    );
        outcome_t res;
        int       lim;
        int       run_len;
        int       run_start;
        int       b;
        int       k;
        res = '0;
        if (op == cba_pkg::FUNC_LOAD) begin
            if (idx < MAP_WORDS) begin
                used_map[idx] = val[WORD_BITS-1:0];
                res.granted = 1'b1;
            end
            return res;
        end
        if (want == 0)
            return res;
        lim = volume_blocks;
        if (lim > MAP_BITS)
            lim = MAP_BITS;
        run_len   = 0;
        run_start = 0;
        for (b = data_start; b < lim; b++) begin
            if (!used_map[b / WORD_BITS][b % WORD_BITS]) begin
                if (run_len == 0)
                    run_start = b;
                run_len++;
                if (run_len == want) begin
                    for (k = run_start; k < run_start + want; k++)
                        used_map[k / WORD_BITS][k % WORD_BITS] = 1'b1;
                    res.granted         = 1'b1;
                    res.run_first_block = run_start[cba_pkg::RES_W-1:0];
                    return res;
                end
            end
            else begin
                run_len = 0;
            end
        end
        return res;
    endfunction

    task automatic flag_result(input string why, input outcome_t exp_o, input outcome_t act_o);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: %s: expected granted=%0b first=%0d, got granted=%0b first=%0d",
                     $time, why, exp_o.granted, exp_o.run_first_block,
                     act_o.granted, act_o.run_first_block);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int w = 0; w < MAP_WORDS; w++)
                used_map[w] = '0;
            volume_blocks = cba_pkg::TOTAL_RESET;
            data_start    = cba_pkg::FDB_RESET;
            awaited_outcomes.delete();
            awaited_count  = 0;
            mismatch_count = 0;
            runs_granted   = 0;
            runs_refused   = 0;
            words_loaded   = 0;
        end
        else begin
            // result strobe is checked before a request taken on the same edge
            if (done) begin
                seen.granted         = granted;
                seen.run_first_block = run_first_block;
                if (awaited_outcomes.size() == 0) begin
                    flag_result("result with nothing outstanding", '0, seen);
                end
                else begin
                    head = awaited_outcomes.pop_front();
                    if (seen.granted !== head.granted
                        || seen.run_first_block !== head.run_first_block)
                        flag_result("result mismatch", head, seen);
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == cba_pkg::REG_TOTAL)
                    volume_blocks = pwdata[cba_pkg::REG_W-1:0];
                else
                    data_start = pwdata[cba_pkg::REG_W-1:0];
            end
            if (start && !busy) begin
                head = first_fit_outcome(func, blocks_wanted, word_index, word_value);
                awaited_outcomes.push_back(head);
                if (func == cba_pkg::FUNC_LOAD)
                    words_loaded++;
                else if (head.granted)
                    runs_granted++;
                else
                    runs_refused++;
            end
            awaited_count = awaited_outcomes.size();
        end
    end

endmodule

### tb/sv/contiguous_bitmap_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contiguous_bitmap_allocator_core_tb
// Drives allocate and bitmap-load requests through the command port and
// reprograms the volume registers over APB between phases. A directed pass
// hits the corner cases, then random phases mix allocations of all sizes, zero and
// oversized included, with bitmap loads mostly inside the search window. Checking lives in cba_alloc_checker.
// ----------------------------------------------------------------------------
module contiguous_bitmap_allocator_core_tb;

    localparam int MAP_BITS     = cba_pkg::MAP_BLOCKS_DEF;
    localparam int WORD_BITS    = cba_pkg::WORD_BITS_DEF;
    localparam int DRAIN_CYCLES = 64;

    localparam logic [cba_pkg::ADDR_W-1:0] ADDR_TOTAL = {cba_pkg::REG_TOTAL, 2'b00};
    localparam logic [cba_pkg::ADDR_W-1:0] ADDR_FDB   = {cba_pkg::REG_FDB, 2'b00};

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        func;
    logic [cba_pkg::WANT_W-1:0]  blocks_wanted;
    logic [cba_pkg::IDX_W-1:0]   word_index;
    logic [cba_pkg::VAL_W-1:0]   word_value;
    logic                        done;
    logic                        granted;
    logic [cba_pkg::RES_W-1:0]   run_first_block;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [cba_pkg::ADDR_W-1:0]  paddr;
    logic [cba_pkg::APB_W-1:0]   pwdata;
    logic [cba_pkg::APB_W-1:0]   prdata;
    logic                        pready;

    int mismatch_count;
    int awaited_count;
    int runs_granted;
    int runs_refused;
    int words_loaded;

    int cur_total;
    int cur_fdb;
    int settings_used;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    contiguous_bitmap_allocator_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .blocks_wanted   (blocks_wanted),
        .word_index      (word_index),
        .word_value      (word_value),
        .done            (done),
        .granted         (granted),
        .run_first_block (run_first_block),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    cba_alloc_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .blocks_wanted   (blocks_wanted),
        .word_index      (word_index),
        .word_value      (word_value),
        .done            (done),
        .granted         (granted),
        .run_first_block (run_first_block),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatch_count  (mismatch_count),
        .awaited_count   (awaited_count),
        .runs_granted    (runs_granted),
        .runs_refused    (runs_refused),
        .words_loaded    (words_loaded)
    );

    // holds start high until the transfer is taken; returns on that edge
    task automatic send_request(
        input logic                         op,
        input logic [cba_pkg::WANT_W-1:0]   want,
        input logic [cba_pkg::IDX_W-1:0]    idx,
        input logic [cba_pkg::VAL_W-1:0]    val
    );
        start         <= 1'b1;
        func          <= op;
        blocks_wanted <= want;
        word_index    <= idx;
        word_value    <= val;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0)
            @(posedge clk);
    endtask

    // bus stays selected after the access phase; the caller releases it
    task automatic apb_write(input logic [cba_pkg::ADDR_W-1:0] addr,
                             input logic [cba_pkg::APB_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // only reprogrammed once the block has gone quiet
    task automatic program_volume(input logic [cba_pkg::APB_W-1:0] total_word,
                                  input logic [cba_pkg::APB_W-1:0] fdb_word);
        wait_drained();
        apb_write(ADDR_TOTAL, total_word);
        apb_write(ADDR_FDB, fdb_word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_total = total_word[cba_pkg::REG_W-1:0];
        cur_fdb   = fdb_word[cba_pkg::REG_W-1:0];
        settings_used++;
    endtask

    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int                         n_items;
        int                         burst_left;
        int                         lim;
        int                         lo_w;
        int                         hi_w;
        int                         t;
        int                         d;
        logic                       op;
        logic [cba_pkg::WANT_W-1:0] want;
        logic [cba_pkg::IDX_W-1:0]  idx;
        logic [cba_pkg::VAL_W-1:0]  val;
        logic [cba_pkg::APB_W-1:0]  total_word;
        logic [cba_pkg::APB_W-1:0]  fdb_word;

        rst_n         <= 1'b0;
        start         <= 1'b0;
        func          <= cba_pkg::FUNC_ALLOC;
        blocks_wanted <= '0;
        word_index    <= '0;
        word_value    <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        cur_total     = cba_pkg::TOTAL_RESET;
        cur_fdb       = cba_pkg::FDB_RESET;
        settings_used = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset volume is empty: nothing can be allocated
        send_request(cba_pkg::FUNC_ALLOC, 16'd1, cba_pkg::IDX_W'($urandom()), $urandom());
        send_request(cba_pkg::FUNC_LOAD, cba_pkg::WANT_W'($urandom()), 10'd0, 32'hA5A5_A5A5);

        // upper register bits are junk and must be dropped
        program_volume(32'hFFFF_0100, 32'hABCD_0000);
        send_request(cba_pkg::FUNC_ALLOC, 16'd0, cba_pkg::IDX_W'($urandom()), $urandom());
        send_request(cba_pkg::FUNC_ALLOC, 16'd1, cba_pkg::IDX_W'($urandom()), $urandom());
        send_request(cba_pkg::FUNC_ALLOC, 16'd3, cba_pkg::IDX_W'($urandom()), $urandom());
        send_request(cba_pkg::FUNC_LOAD, cba_pkg::WANT_W'($urandom()), 10'd1, 32'h0000_0000);
        send_request(cba_pkg::FUNC_LOAD, cba_pkg::WANT_W'($urandom()), 10'd2, 32'hFFFF_FFFF);
        send_request(cba_pkg::FUNC_ALLOC, 16'd40, cba_pkg::IDX_W'($urandom()), $urandom());
        send_request(cba_pkg::FUNC_ALLOC, 16'hFFFF, cba_pkg::IDX_W'($urandom()), $urandom());
        send_request(cba_pkg::FUNC_ALLOC, 16'h8000, cba_pkg::IDX_W'($urandom()), $urandom());
        send_request(cba_pkg::FUNC_LOAD, cba_pkg::WANT_W'($urandom()), 10'd7, 32'h8000_0000);
        send_request(cba_pkg::FUNC_ALLOC, 16'd150, cba_pkg::IDX_W'($urandom()), $urandom());
        send_request(cba_pkg::FUNC_LOAD, cba_pkg::WANT_W'($urandom()), 10'd1023, 32'hFFFF_FFFF);

        // oversized volume, search confined to the top word of the map
        program_volume(32'h0000_FFFF, MAP_BITS - WORD_BITS);
        send_request(cba_pkg::FUNC_ALLOC, 16'd1, cba_pkg::IDX_W'($urandom()), $urandom());
        send_request(cba_pkg::FUNC_LOAD, cba_pkg::WANT_W'($urandom()), 10'd1023, 32'h0000_00FF);
        send_request(cba_pkg::FUNC_ALLOC, 16'd24, cba_pkg::IDX_W'($urandom()), $urandom());
        send_request(cba_pkg::FUNC_ALLOC, 16'd1, cba_pkg::IDX_W'($urandom()), $urandom());
        send_request(cba_pkg::FUNC_LOAD, cba_pkg::WANT_W'($urandom()), 10'd1023, 32'h0000_0000);
        send_request(cba_pkg::FUNC_ALLOC, 16'd32, cba_pkg::IDX_W'($urandom()), $urandom());

        // start at or above the limit: empty range
        program_volume(32'h0000_FFFF, 32'h0000_FFFF);
        send_request(cba_pkg::FUNC_ALLOC, 16'd1, cba_pkg::IDX_W'($urandom()), $urandom());
        program_volume(32'h0000_FFFF, MAP_BITS);
        send_request(cba_pkg::FUNC_ALLOC, 16'd1, cba_pkg::IDX_W'($urandom()), $urandom());

        burst_left = 0;
        for (int p = 0; p < 10; p++) begin
            total_word = $urandom();
            fdb_word   = $urandom();
            case (p)
                0: begin
                    total_word[15:0] = 16'hFFFF;
                    fdb_word[15:0]   = 16'd0;
                end
                1: begin
                    total_word[15:0] = 16'(MAP_BITS);
                    fdb_word[15:0]   = 16'(MAP_BITS - WORD_BITS * $urandom_range(2, 48));
                end
                2: begin
                    t = $urandom_range(0, 65535);
                    d = $urandom_range(0, 1500);
                    total_word[15:0] = 16'(t);
                    fdb_word[15:0]   = 16'((t > d) ? t - d : 0);
                end
                default: begin
                    total_word[15:0] = 16'($urandom_range(64, 2048));
                    fdb_word[15:0]   = 16'($urandom_range(0, 64));
                end
            endcase
            program_volume(total_word, fdb_word);
            lim  = (cur_total > MAP_BITS) ? MAP_BITS : cur_total;
            lo_w = cur_fdb / WORD_BITS;
            hi_w = (lim == 0) ? -1 : (lim - 1) / WORD_BITS;
            n_items = (p == 0) ? 15 : 60;

            for (int i = 0; i < n_items; i++) begin
                op  = ($urandom_range(0, 99) < 70) ? cba_pkg::FUNC_ALLOC : cba_pkg::FUNC_LOAD;
                idx = cba_pkg::IDX_W'($urandom());
                if (lo_w <= hi_w && $urandom_range(0, 99) < 85)
                    idx = cba_pkg::IDX_W'($urandom_range(lo_w, hi_w));
                case ($urandom_range(0, 4))
                    0:       val = '0;
                    1:       val = '1;
                    2:       val = $urandom() & $urandom() & $urandom();
                    3:       val = $urandom();
                    default: val = $urandom() | $urandom();
                endcase
                d = $urandom_range(0, 99);
                if (d < 3)
                    want = '0;
                else if (d < 43)
                    want = cba_pkg::WANT_W'($urandom_range(1, 8));
                else if (d < 78)
                    want = cba_pkg::WANT_W'($urandom_range(9, 64));
                else if (d < 93)
                    want = cba_pkg::WANT_W'($urandom_range(65, 400));
                else
                    want = cba_pkg::WANT_W'($urandom());
                send_request(op, want, idx, val);

                if ($urandom_range(0, 99) < 4) begin
                    wait_drained();
                end
                else if (burst_left == 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                    burst_left = $urandom_range(1, 30);
                end
                else begin
                    burst_left--;
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d volume settings: %0d runs granted, %0d refused, %0d words loaded",
                 settings_used, runs_granted, runs_refused, words_loaded);
        $display("Mismatches: %0d", mismatch_count);
        if (mismatch_count == 0 && awaited_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
